// File: rtl/core/button_debounce_repeat_queue_macros.svh
// Assertion macros used by the back end of the button debounce and repeat queue RTL.
// Depends on nothing; defining NO_ASSERTIONS turns every check into nothing.
`ifndef BUTTON_DEBOUNCE_REPEAT_QUEUE_MACROS_SVH
`define BUTTON_DEBOUNCE_REPEAT_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked property, switched off while reset is held.
`define BDRQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define BDRQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDRQ_ASSERT(label, clk, rst_n, prop, msg)
`define BDRQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/core/bdrq_pkg.sv
// Package for the button debounce and repeat queue: payload types, register map,
// reset values and the back-end state type. Depends on nothing.
package bdrq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_DELAY    = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_MASK     = 2'd3;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd30;
  localparam logic [15:0] DELAY_RST    = 16'd2000;
  localparam logic [15:0] INTERVAL_RST = 16'd500;
  localparam logic [2:0]  MASK_RST     = 3'd6;

  localparam logic [1:0] BTN_LAST = 2'd2;

  typedef struct packed {
    logic cmd;
    logic ok_level;
    logic plus_level;
    logic minus_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] button_id;
    logic       last_event;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic       valid;
    logic       is_drain;
    logic [2:0] lvl;      // bit0 ok, bit1 plus, bit2 minus
  } cmd_if_t;

  typedef struct packed {
    logic [7:0]  debounce;
    logic [15:0] delay;
    logic [15:0] interval;
    logic [2:0]  mask;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DEB,
    BK_REP,
    BK_DRN_RD,
    BK_DRN_WAIT
  } bk_state_t;

endpackage

// File: rtl/core/bdrq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module bdrq_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bdrq_front.sv
// Front end: accepts input items, classifies them as tick or drain and holds
// them in a two-entry command queue. Depends on bdrq_pkg.
module bdrq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  bdrq_pkg::in_item_t in_data,
  output bdrq_pkg::cmd_if_t cmd,
  input  logic              cmd_pop
);
  import bdrq_pkg::*;

  cmd_if_t    slot_r [2];
  logic       wr_idx_r;
  logic       rd_idx_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;
  cmd_if_t    cls;

  always_comb begin
    cls.valid    = 1'b1;
    cls.is_drain = (in_data.cmd == CMD_DRAIN);
    cls.lvl      = {in_data.minus_level, in_data.plus_level, in_data.ok_level};
  end

  assign full    = cnt_r[1];
  assign do_push = push && !full;
  assign do_pop  = cmd_pop && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_idx_r] <= cls;
    end
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_idx_r <= !wr_idx_r;
      end
      if (do_pop) begin
        rd_idx_r <= !rd_idx_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_comb begin
    cmd       = slot_r[rd_idx_r];
    cmd.valid = (cnt_r != 2'd0);
  end

endmodule

// File: rtl/core/bdrq_back.sv
// Back end: runs tick commands one button phase per cycle, keeps the event ring
// in a RAM and drains it into the output register. Depends on bdrq_pkg, bdrq_ram.
module bdrq_back #(
  parameter int unsigned QUEUE_DEPTH = bdrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bdrq_pkg::cfg_t     cfg,
  input  bdrq_pkg::cmd_if_t  cmd,
  output logic               cmd_pop,
  output logic               out_vld,
  output bdrq_pkg::out_item_t out_data,
  input  logic               pop
);
  import bdrq_pkg::*;
  `include "button_debounce_repeat_queue_macros.svh"

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  bk_state_t   state_r, state_nxt;
  logic [1:0]  k_r;
  logic [2:0]  lvl_r;
  logic [15:0] tick_r;
  logic [2:0]  stable_r;
  logic [7:0]  dbc_r   [3];
  logic [15:0] press_r [3];
  logic [15:0] lastr_r [3];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_inc, rd_ptr_inc;
  logic        out_vld_r;
  out_item_t   out_r;

  logic        sel_lvl, sel_st;
  logic [7:0]  sel_cnt, cnt_inc, cnt_nxt;
  logic        flip, press;
  logic [15:0] held, since;
  logic        rep_fire, enq_req, q_full, ev_we;
  logic        start_tick, deb_step, rep_step, rd_issue, out_load, slot_free;
  logic [1:0]  ram_q;

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign q_full     = (wr_ptr_inc == rd_ptr_r);
  assign slot_free  = !out_vld_r || pop;

  // Debounce of the selected button.
  always_comb begin
    sel_lvl = lvl_r[k_r];
    sel_st  = stable_r[k_r];
    sel_cnt = dbc_r[k_r];
    cnt_inc = (sel_cnt < cfg.debounce) ? sel_cnt + 8'd1 : sel_cnt;
    flip    = (sel_lvl != sel_st) && (cnt_inc >= cfg.debounce);
    cnt_nxt = ((sel_lvl == sel_st) || flip) ? 8'd0 : cnt_inc;
    press   = flip && !sel_lvl;
  end

  // Auto-repeat of the selected button; differences wrap at 16 bits.
  always_comb begin
    held     = tick_r - press_r[k_r];
    since    = tick_r - lastr_r[k_r];
    rep_fire = cfg.mask[k_r] && !sel_st && (held >= cfg.delay) && (since >= cfg.interval);
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_pop    = 1'b0;
    start_tick = 1'b0;
    deb_step   = 1'b0;
    rep_step   = 1'b0;
    rd_issue   = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (cmd.valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_drain) begin
            state_nxt = BK_DRN_RD;
          end else begin
            start_tick = 1'b1;
            state_nxt  = BK_DEB;
          end
        end
      end
      BK_DEB: begin
        deb_step  = 1'b1;
        state_nxt = BK_REP;
      end
      BK_REP: begin
        rep_step  = 1'b1;
        state_nxt = (k_r == BTN_LAST) ? BK_IDLE : BK_DEB;
      end
      BK_DRN_RD: begin
        if (rd_ptr_r == wr_ptr_r) begin
          state_nxt = BK_IDLE;
        end else begin
          rd_issue  = 1'b1;
          state_nxt = BK_DRN_WAIT;
        end
      end
      BK_DRN_WAIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = BK_DRN_RD;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign enq_req = (deb_step && press) || (rep_step && rep_fire);
  assign ev_we   = enq_req && !q_full;

  bdrq_ram #(
    .WIDTH (2),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (wr_ptr_r),
    .wdata (k_r),
    .re    (rd_issue),
    .raddr (rd_ptr_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      k_r       <= 2'd0;
      tick_r    <= 16'd0;
      stable_r  <= 3'b111;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        dbc_r[i]   <= 8'd0;
        press_r[i] <= 16'd0;
        lastr_r[i] <= 16'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (start_tick) begin
        tick_r <= tick_r + 16'd1;
        lvl_r  <= cmd.lvl;
        k_r    <= 2'd0;
      end
      if (deb_step) begin
        dbc_r[k_r] <= cnt_nxt;
        if (flip) begin
          stable_r[k_r] <= sel_lvl;
        end
        if (press) begin
          press_r[k_r] <= tick_r;
          lastr_r[k_r] <= tick_r;
        end
      end
      if (rep_step) begin
        if (rep_fire) begin
          lastr_r[k_r] <= tick_r;
        end
        k_r <= k_r + 2'd1;
      end
      if (ev_we) begin
        wr_ptr_r <= wr_ptr_inc;
      end
      if (out_load) begin
        rd_ptr_r  <= rd_ptr_inc;
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.button_id  <= ram_q;
      out_r.last_event <= (rd_ptr_inc == wr_ptr_r);
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

  `BDRQ_ASSERT(a_no_write_full, clk, rst_n, ev_we |-> (wr_ptr_inc != rd_ptr_r), "event written into a full ring")
  `BDRQ_ASSERT(a_tick_keeps_rd, clk, rst_n, (state_r == BK_DEB || state_r == BK_REP) |=> $stable(rd_ptr_r), "read pointer moved during a tick")
  `BDRQ_ASSERT(a_out_held, clk, rst_n, (out_vld_r && !pop) |=> (out_vld_r && $stable(out_r)), "waiting result overwritten")
  `BDRQ_ASSERT(a_k_range, clk, rst_n, (state_r == BK_DEB || state_r == BK_REP) |-> (k_r <= BTN_LAST), "button index out of range")

endmodule

// File: rtl/core/button_debounce_repeat_queue.sv
// Three-button debouncer with auto-repeat and an event ring; top level.
// Input channel: push/full carry in_data (cmd, ok, plus, minus levels). A tick
// item (cmd 0) advances the millisecond count and debounces the buttons; a drain
// item (cmd 1) sends every queued event out, oldest first, the final one marked.
// Result channel: empty/pop carry out_data (button_id, last_event).
// Configuration: APB-style registers at byte addresses 0, 4, 8 and 12 for the
// debounce count, repeat delay, repeat interval and repeat enable mask.
// Items pass through a two-entry command queue, so the sender may push while
// the back end is busy. The back end runs one command at a time: a tick is a
// dispatch step plus a debounce and a repeat phase per button, each phase
// able to write one event into the ring RAM. A drain is dispatched, then for
// each event reads the RAM and, as the read is registered, then loads the
// result into the output register; it ends when the ring is empty. If the
// receiver stalls, the output register holds its result and the drain waits;
// the command queue keeps accepting until it is full.
// Reset restores the control registers and empties both queues; the ring RAM needs no
// clearing pass. The ring keeps QUEUE_DEPTH-1 events; further events are lost.
module button_debounce_repeat_queue #(
  parameter int unsigned QUEUE_DEPTH = bdrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  bdrq_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output bdrq_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bdrq_pkg::*;

  cfg_t    cfg_r;
  cmd_if_t cmd;
  logic    cmd_pop;
  logic    out_vld;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= DEBOUNCE_RST;
      cfg_r.delay    <= DELAY_RST;
      cfg_r.interval <= INTERVAL_RST;
      cfg_r.mask     <= MASK_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_DEBOUNCE: cfg_r.debounce <= pwdata[7:0];
        REG_DELAY:    cfg_r.delay    <= pwdata[15:0];
        REG_INTERVAL: cfg_r.interval <= pwdata[15:0];
        REG_MASK:     cfg_r.mask     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEBOUNCE: prdata = {24'd0, cfg_r.debounce};
      REG_DELAY:    prdata = {16'd0, cfg_r.delay};
      REG_INTERVAL: prdata = {16'd0, cfg_r.interval};
      REG_MASK:     prdata = {29'd0, cfg_r.mask};
      default:      prdata = 32'd0;
    endcase
  end

  bdrq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  bdrq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_vld  (out_vld),
    .out_data (out_data),
    .pop      (pop)
  );

  assign empty = !out_vld;

endmodule

// File: test/button_debounce_repeat_queue_tb.sv
// Self-checking testbench for the button debounce and auto-repeat event queue.
// Drives tick and drain items, predicts every drained event, checks register reads.
// Depends on bdrq_pkg and the button_debounce_repeat_queue top level.
module button_debounce_repeat_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdrq_pkg::*;

  localparam int unsigned RING_SIZE = QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic            cfg_row;  // write a register instead of pushing an item
    logic [1:0]      reg_idx;
    logic [15:0]     reg_val;
    in_item_t        item;
    logic            typed;    // expected events are written into the row
    logic [2:0]      n_exp;
    out_item_t [6:0] exp;
  } dir_row_t;

  typedef struct {
    int deb;
    int delay;
    int interval;
    int mask;
    int hold_lo;
    int hold_hi;
    int items;
    int noise_pct;
    bit alternate;
    int send_pct;
    int recv_pct;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned errors = 0;
  int          send_pct = 0;
  int          recv_pct = 0;

  // Shadow registers and button state of the predictor.
  logic [7:0]  cfg_debounce = DEBOUNCE_RST;
  logic [15:0] cfg_delay = DELAY_RST;
  logic [15:0] cfg_interval = INTERVAL_RST;
  logic [2:0]  cfg_mask = MASK_RST;

  logic [15:0] tick_now = '0;
  logic [2:0]  stable_lvl = 3'b111;
  logic [7:0]  bounce_cnt [3] = '{default: '0};
  logic [15:0] press_at [3] = '{default: '0};
  logic [15:0] repeat_at [3] = '{default: '0};
  logic [1:0]  ring [RING_SIZE] = '{default: '0};
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;

  out_item_t   events_due [$];
  dir_row_t    dir_tab [$];

  phase_t phases [7] = '{
    '{30, 2000, 500, 6, 1, 40, 30, 8, 1'b0, 26, 59},
    '{0, 0, 0, 7, 1, 6, 30, 8, 1'b0, 26, 59},
    '{1, 3, 2, 5, 1, 10, 30, 8, 1'b0, 59, 26},
    '{24, 0, 65535, 3, 25, 27, 40, 0, 1'b1, 59, 26},
    '{2, 65535, 65535, 7, 1, 8, 25, 8, 1'b0, 0, 0},
    '{3, 5, 0, 2, 1, 14, 30, 8, 1'b0, 0, 0},
    '{1, 0, 0, 0, 1, 20, 30, 8, 1'b0, 0, 0}
  };

  button_debounce_repeat_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Events pushed while the ring holds RING_SIZE-1 entries are lost.
  task automatic queue_event(input int k);
    int unsigned nxt;
    nxt = (wr_ptr + 1) % RING_SIZE;
    if (nxt != rd_ptr) begin
      ring[wr_ptr] = 2'(k);
      wr_ptr = nxt;
    end
  endtask

  task automatic debounce_button(input int k, input logic lvl);
    logic [15:0] held;
    logic [15:0] since;
    if (lvl == stable_lvl[k]) begin
      bounce_cnt[k] = '0;
    end else begin
      if (bounce_cnt[k] < cfg_debounce) bounce_cnt[k] = bounce_cnt[k] + 8'd1;
      if (bounce_cnt[k] >= cfg_debounce) begin
        stable_lvl[k] = lvl;
        bounce_cnt[k] = '0;
        if (lvl == 1'b0) begin
          press_at[k] = tick_now;
          repeat_at[k] = tick_now;
          queue_event(k);
        end
      end
    end
    if (cfg_mask[k] && stable_lvl[k] == 1'b0) begin
      held = tick_now - press_at[k];
      since = tick_now - repeat_at[k];
      if (held >= cfg_delay && since >= cfg_interval) begin
        repeat_at[k] = tick_now;
        queue_event(k);
      end
    end
  endtask

  // Advances the predicted state by one item; drained events are queued when keep is set.
  task automatic predict_events(input in_item_t it, input logic keep);
    out_item_t ev;
    if (it.cmd == CMD_TICK) begin
      tick_now = tick_now + 16'd1;
      debounce_button(0, it.ok_level);
      debounce_button(1, it.plus_level);
      debounce_button(2, it.minus_level);
    end else begin
      while (rd_ptr != wr_ptr) begin
        ev.button_id = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % RING_SIZE;
        ev.last_event = (rd_ptr == wr_ptr);
        if (keep) events_due.push_back(ev);
      end
    end
  endtask

  task automatic send_item(input in_item_t it, input logic keep);
    while ($urandom_range(0, 99) < send_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    predict_events(it, keep);
  endtask

  // The block is idle once every event has left and any tick in flight has finished.
  task automatic settle();
    push <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read %h, want %h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE: begin
        cfg_debounce = val[7:0];
        readback = {24'd0, cfg_debounce};
      end
      REG_DELAY: begin
        cfg_delay = val;
        readback = {16'd0, cfg_delay};
      end
      REG_INTERVAL: begin
        cfg_interval = val;
        readback = {16'd0, cfg_interval};
      end
      default: begin
        cfg_mask = val[2:0];
        readback = {29'd0, cfg_mask};
      end
    endcase
    check_register(idx, readback);
  endtask

  // lv is {minus, plus, ok}; ids lists the expected button of each drained event.
  function automatic dir_row_t item_row(input logic cmd, input logic [2:0] lv,
                                        input logic typed, input string ids);
    dir_row_t r;
    r = '0;
    r.item.cmd = cmd;
    r.item.ok_level = lv[0];
    r.item.plus_level = lv[1];
    r.item.minus_level = lv[2];
    r.typed = typed;
    r.n_exp = 3'(ids.len());
    for (int i = 0; i < ids.len(); i++) begin
      r.exp[i].button_id = 2'(ids.getc(i) - 8'd48);
      r.exp[i].last_event = (i == ids.len() - 1);
    end
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
    dir_row_t r;
    r = '0;
    r.cfg_row = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic in_item_t drain_item();
    in_item_t it;
    it = 4'($urandom_range(0, 15));
    it.cmd = CMD_DRAIN;
    return it;
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && pop && empty === 1'b0) begin
        if (events_due.size() == 0) begin
          report_mismatch($sformatf("event %0d arrived with none expected",
                                    out_data.button_id));
        end else begin
          if (out_data.button_id !== events_due[0].button_id)
            report_mismatch($sformatf("button_id %0d, want %0d",
                                      out_data.button_id, events_due[0].button_id));
          if (out_data.last_event !== events_due[0].last_event)
            report_mismatch($sformatf("last_event %0b, want %0b",
                                      out_data.last_event, events_due[0].last_event));
          void'(events_due.pop_front());
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_item_t   it;
    logic [2:0] pattern;
    logic [2:0] lv;
    int         len;
    int         sent;
    int         idx;

    // Empty drain and one tick under the reset settings, then quick presses.
    dir_tab.push_back(item_row(CMD_DRAIN, 3'b000, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b1, ""));
    dir_tab.push_back(reg_row(REG_DEBOUNCE, 16'd1));
    dir_tab.push_back(reg_row(REG_DELAY, 16'hFFFF));
    dir_tab.push_back(reg_row(REG_INTERVAL, 16'hFFFF));
    dir_tab.push_back(reg_row(REG_MASK, 16'd0));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_DRAIN, 3'b111, 1'b1, "012"));
    dir_tab.push_back(item_row(CMD_DRAIN, 3'b010, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b111, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b110, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b111, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b101, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b111, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b011, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_DRAIN, 3'b101, 1'b1, "01201"));
    // Three full press rounds overflow the ring: the last two events are lost.
    dir_tab.push_back(item_row(CMD_TICK, 3'b111, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b111, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b111, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b1, ""));
    dir_tab.push_back(item_row(CMD_DRAIN, 3'b000, 1'b1, "0120120"));
    // Zero delay and interval: every held button repeats on every tick.
    dir_tab.push_back(reg_row(REG_MASK, 16'd7));
    dir_tab.push_back(reg_row(REG_DELAY, 16'd0));
    dir_tab.push_back(reg_row(REG_INTERVAL, 16'd0));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b0, ""));
    dir_tab.push_back(item_row(CMD_TICK, 3'b000, 1'b0, ""));
    dir_tab.push_back(item_row(CMD_DRAIN, 3'b111, 1'b0, ""));

    phases[6].deb = $urandom_range(1, 6);
    phases[6].delay = $urandom_range(0, 12);
    phases[6].interval = $urandom_range(0, 6);
    phases[6].mask = $urandom_range(0, 7);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_register(REG_DEBOUNCE, {24'd0, DEBOUNCE_RST});
    check_register(REG_DELAY, {16'd0, DELAY_RST});
    check_register(REG_INTERVAL, {16'd0, INTERVAL_RST});
    check_register(REG_MASK, {29'd0, MASK_RST});

    send_pct = 26;
    recv_pct = 59;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_row) begin
        settle();
        write_register(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_item(dir_tab[i].item, !dir_tab[i].typed);
        if (dir_tab[i].typed)
          for (int j = 0; j < dir_tab[i].n_exp; j++) events_due.push_back(dir_tab[i].exp[j]);
      end
    end

    foreach (phases[p]) begin
      settle();
      send_pct = phases[p].send_pct;
      recv_pct = phases[p].recv_pct;
      write_register(REG_DEBOUNCE, 16'(phases[p].deb));
      write_register(REG_DELAY, 16'(phases[p].delay));
      write_register(REG_INTERVAL, 16'(phases[p].interval));
      write_register(REG_MASK, 16'(phases[p].mask));
      sent = 0;
      pattern = 3'b111;
      // Each segment holds one button pattern, with occasional bounces and drains.
      while (sent < phases[p].items) begin
        pattern = phases[p].alternate ? ~pattern : 3'($urandom_range(0, 7));
        len = $urandom_range(phases[p].hold_lo, phases[p].hold_hi);
        for (int i = 0; i < len; i++) begin
          lv = pattern;
          if ($urandom_range(0, 99) < phases[p].noise_pct) begin
            idx = $urandom_range(0, 2);
            lv[idx] = ~lv[idx];
          end
          it.cmd = CMD_TICK;
          it.ok_level = lv[0];
          it.plus_level = lv[1];
          it.minus_level = lv[2];
          send_item(it, 1'b1);
          sent++;
          if ($urandom_range(0, 99) < 3) send_item(drain_item(), 1'b1);
        end
        if ($urandom_range(0, 1) == 1) send_item(drain_item(), 1'b1);
      end
      send_item(drain_item(), 1'b1);
    end

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bdrq_pkg.sv
rtl/core/bdrq_ram.sv
rtl/core/bdrq_front.sv
rtl/core/bdrq_back.sv
rtl/core/button_debounce_repeat_queue.sv
test/button_debounce_repeat_queue_tb.sv
